@@ src/nkt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nkt_pkg;

  // Fixed field widths of the request, response and configuration channels.
  localparam int FUNC_W = 2;
  localparam int ID_W   = 11;
  localparam int KEY_W  = 11;
  localparam int CNT_W  = 11;

  // Value of the entry count register after reset.
  localparam int COUNT_RESET = 1024;

  // Operation codes carried in the func field; the fourth code is unused.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_DELETE = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CHANGE = 2'd2
  } func_t;

  // Control from the scan sequencer to the compare unit.
  typedef struct packed {
    logic            start;  // clear the predecessor and successor trackers
    logic            take;   // entry data from the memories is valid this cycle
    logic [ID_W-1:0] id;     // id of the entry whose data is valid
  } scan_ctl_t;

endpackage

`default_nettype wire

@@ src/nkt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: operation, entry id and key or query value.
interface nkt_req_if import nkt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   entry_id;
  logic [KEY_W-1:0]  key_value;

  modport source (output valid, output func, output entry_id, output key_value,
                  input ready);
  modport sink   (input valid, input func, input entry_id, input key_value,
                  output ready);
endinterface

// Response channel: id of the nearest present entry.
interface nkt_rsp_if import nkt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] result_id;

  modport source (output valid, output result_id, input ready);
  modport sink   (input valid, input result_id, output ready);
endinterface

// Configuration channel: write data of the entry count register.
interface nkt_cfg_if import nkt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output entry_count, input ready);
  modport sink   (input valid, input entry_count, output ready);
endinterface

`default_nettype wire

@@ src/nearest_key_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Payload                       Moves
// -------  -------  ----------------------------  ------------------------------------
// req      sink     func, entry_id, key_value     one delete, query or change request
// rsp      source   result_id                     one response for each query request
// cfg      sink     entry_count                   one write of the entry count register
//
// A delete request clears the present bit and a change request writes the key and sets
// the bit, both in the cycle the request is accepted. A query request runs a scan that
// reads one entry per cycle from the memory read port, up to the effective count.
// After reset the block runs a clearing pass over all MAX_ENTRIES entries that restores
// every key to its own id and marks every entry present; req.ready stays low meanwhile.
// A stalled response holds in the output register; a new request is still accepted,
// and a following query waits at its end until the output register is free.

module nearest_key_table_unit import nkt_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  nkt_req_if.sink   req,
  nkt_rsp_if.source rsp,
  nkt_cfg_if.sink   cfg
);

  // Address width of the memories, and a count width that holds MAX_ENTRIES as well
  // as any value of the entry count register.
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_cnt;
  logic [EW-1:0]    rd_cnt;
  logic             rd_pend;
  logic [ID_W-1:0]  rd_id;
  logic [KEY_W-1:0] query_value;
  logic [CNT_W-1:0] entry_count;
  logic             out_valid;
  logic [ID_W-1:0]  out_id;

  logic [EW-1:0]    eff_count;
  logic [EW-1:0]    count_ext;
  logic [EW-1:0]    id_ext;
  logic [EW-1:0]    id_idx_full;
  logic [EW-1:0]    clr_id_full;
  logic [EW-1:0]    rd_next_full;
  logic             id_ok;
  logic             req_fire;
  func_t            req_func;

  logic             key_we;
  logic             pres_we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] key_wdata;
  logic             pres_wdata;
  logic [KEY_W-1:0] key_rdata;
  logic             pres_rdata;

  scan_ctl_t        scan_ctl;
  logic [ID_W-1:0]  scan_result;

  // The entry count is saturated at the table size; ids 1 through that count are live.
  assign count_ext = EW'(entry_count);
  assign eff_count = (count_ext > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : count_ext;

  assign id_ext       = EW'(req.entry_id);
  assign id_ok        = (req.entry_id != '0) && (id_ext <= eff_count);
  assign id_idx_full  = id_ext - EW'(1);
  assign clr_id_full  = EW'(clr_cnt) + EW'(1);
  assign rd_next_full = rd_cnt + EW'(1);

  assign req_func = func_t'(req.func);
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // The user must have configuration writes arrive only while the block idles; unchecked.
  assign cfg.ready = 1'b1;

  assign rsp.valid     = out_valid;
  assign rsp.result_id = out_id;

  // Write port of both memories. The clearing pass owns it after reset; afterwards a
  // delete clears only the present bit, while a change writes the key and sets the bit.
  always_comb begin
    key_we     = 1'b0;
    pres_we    = 1'b0;
    waddr      = id_idx_full[AW-1:0];
    key_wdata  = req.key_value;
    pres_wdata = 1'b0;
    case (state)
      ST_CLEAR: begin
        key_we     = 1'b1;
        pres_we    = 1'b1;
        waddr      = clr_cnt;
        key_wdata  = clr_id_full[KEY_W-1:0];
        pres_wdata = 1'b1;
      end
      ST_IDLE: begin
        if (req_fire && id_ok) begin
          case (req_func)
            FUNC_DELETE: begin
              pres_we = 1'b1;
            end
            FUNC_CHANGE: begin
              key_we     = 1'b1;
              pres_we    = 1'b1;
              pres_wdata = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // The scan reads entry rd_cnt; its data and id reach the compare unit in the next cycle,
  // flagged by rd_pend.
  assign scan_ctl.start = req_fire && (req_func == FUNC_QUERY);
  assign scan_ctl.take  = rd_pend;
  assign scan_ctl.id    = rd_id;

  nkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (key_rdata)
  );

  nkt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ENTRIES)
  ) u_present_ram (
    .clk   (clk),
    .we    (pres_we),
    .waddr (waddr),
    .wdata (pres_wdata),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (pres_rdata)
  );

  nkt_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctl           (scan_ctl),
    .value         (query_value),
    .entry_key     (key_rdata),
    .entry_present (pres_rdata),
    .result_id     (scan_result)
  );

  // Sequencer: clearing pass, idle, entry scan, and delivery into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      rd_cnt      <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
      entry_count <= CNT_W'(COUNT_RESET);
    end else begin
      if (cfg.valid && cfg.ready) begin
        entry_count <= cfg.entry_count;
      end
      // The output register loads a finished query as soon as it is free or drains.
      if ((state == ST_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire && (req_func == FUNC_QUERY)) begin
            query_value <= req.key_value;
            rd_cnt      <= '0;
            rd_pend     <= 1'b0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt < eff_count) begin
            rd_pend <= 1'b1;
            rd_id   <= rd_next_full[ID_W-1:0];
            rd_cnt  <= rd_next_full;
          end else begin
            rd_pend <= 1'b0;
            // The last entry has been compared once no read is in flight.
            if (!rd_pend) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_id <= scan_result;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No request may write the memories while a scan reads them.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !(key_we || pres_we))
    else $error("memory written during a query scan");

  // The scan never reads past the last live entry.
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_cnt <= eff_count))
    else $error("scan read beyond the effective count");

  // An accepted query always starts a scan.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req_func == FUNC_QUERY)) |=> (state == ST_SCAN))
    else $error("accepted query did not start a scan");

  // A response appears only at the end of a scan.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("response raised outside the delivery state");
`endif

endmodule

`default_nettype wire

@@ src/nkt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/nkt_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nkt_scan import nkt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  input  logic [KEY_W-1:0] value,
  input  logic [KEY_W-1:0] entry_key,
  input  logic             entry_present,
  output logic [ID_W-1:0]  result_id
);

  logic             has_pred;
  logic             has_succ;
  logic [KEY_W-1:0] pred_key;
  logic [KEY_W-1:0] succ_key;
  logic [ID_W-1:0]  pred_id;
  logic [ID_W-1:0]  succ_id;
  logic [KEY_W-1:0] pred_dist;
  logic [KEY_W-1:0] succ_dist;

  // Entries arrive in ascending id order, so ">=" lets the highest id win among
  // equal predecessor keys and "<" lets the lowest id win among successor keys.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      has_pred <= 1'b0;
      has_succ <= 1'b0;
    end else if (ctl.take && entry_present) begin
      if (entry_key <= value) begin
        if (!has_pred || entry_key >= pred_key) begin
          has_pred <= 1'b1;
          pred_key <= entry_key;
          pred_id  <= ctl.id;
        end
      end else begin
        if (!has_succ || entry_key < succ_key) begin
          has_succ <= 1'b1;
          succ_key <= entry_key;
          succ_id  <= ctl.id;
        end
      end
    end
  end

  assign pred_dist = value - pred_key;
  assign succ_dist = succ_key - value;

  always_comb begin
    if (!has_pred && !has_succ) begin
      result_id = '0;
    end else if (!has_pred) begin
      result_id = succ_id;
    end else if (!has_succ) begin
      result_id = pred_id;
    end else if (succ_dist < pred_dist) begin
      result_id = succ_id;
    end else begin
      result_id = pred_id;
    end
  end

endmodule

`default_nettype wire
